### design/irr_pkg.sv
// Package for the interrupt line router: sizes, transaction types, route lookup.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package irr_pkg;

    localparam int NUM_LINES = 8;
    localparam int CPU_COUNT = 4;
    localparam int CPU_SLOT  = 4;
    localparam int LINE_W    = 8;
    localparam int CPU_W     = 4;
    localparam int ROUTE_W   = 32;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_WRITE  = 1'b1;

    localparam logic [ROUTE_W-1:0] ROUTE_RESET = 32'h1111_1111;

    typedef logic [LINE_W-1:0] line_vec_t;
    typedef logic [CPU_W-1:0]  cpu_vec_t;

    typedef struct packed {
        line_vec_t enable_value;
        line_vec_t line_levels;
        logic      action;
    } irr_item_t;

    typedef struct packed {
        line_vec_t enable_now;
        line_vec_t masked_status;
        cpu_vec_t  drop_mask;
        cpu_vec_t  raise_mask;
    } irr_result_t;

    // Lines at or above NUM_LINES never see an edge.
    function automatic line_vec_t active_lines();
        line_vec_t m;
        m = '0;
        for (int i = 0; i < LINE_W; i++)
        begin
            if (i < NUM_LINES)
            begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic logic routed(logic [ROUTE_W-1:0] map, int line, int cpu);
        int pos;
        pos = line * CPU_SLOT + cpu;
        if (cpu >= CPU_SLOT || pos >= ROUTE_W)
        begin
            return 1'b0;
        end
        return map[pos[4:0]];
    endfunction

endpackage

`default_nettype wire

### design/irr_in_reg.sv
// Input register of the interrupt line router: holds one accepted transaction.
// Depends on irr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irr_in_reg (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                load,
    input  wire                drain,
    input  irr_pkg::irr_item_t item_in,
    output logic               valid,
    output irr_pkg::irr_item_t item_out
);

    logic               valid_reg;
    logic               valid_next;
    irr_pkg::irr_item_t item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (drain)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign valid    = valid_reg;
    assign item_out = item_reg;

endmodule

`default_nettype wire

### design/irr_engine.sv
// Routing state and single-pass edge/enable update of the interrupt line router.
// Depends on irr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irr_engine (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire  [irr_pkg::ROUTE_W-1:0]  cfg_wdata,
    input  wire                          fire,
    input  irr_pkg::irr_item_t           item,
    output irr_pkg::irr_result_t         result
);

    logic [irr_pkg::ROUTE_W-1:0] route_reg;
    irr_pkg::line_vec_t prev_reg, prev_next;
    irr_pkg::line_vec_t graw_reg, graw_next;
    irr_pkg::line_vec_t en_reg, en_next;
    logic [irr_pkg::CPU_COUNT-1:0][irr_pkg::LINE_W-1:0] raw_reg, raw_next;
    logic [irr_pkg::CPU_COUNT-1:0][irr_pkg::LINE_W-1:0] pend_reg, pend_next;

    irr_pkg::line_vec_t rise;
    irr_pkg::line_vec_t fall;
    irr_pkg::line_vec_t rt;
    irr_pkg::line_vec_t er;
    irr_pkg::line_vec_t ef;
    irr_pkg::line_vec_t lo;
    irr_pkg::line_vec_t hi;
    irr_pkg::line_vec_t pend_before;
    irr_pkg::line_vec_t pend_after;
    irr_pkg::cpu_vec_t  up;
    irr_pkg::cpu_vec_t  down;

    always_comb
    begin
        prev_next = prev_reg;
        graw_next = graw_reg;
        en_next   = en_reg;
        raw_next  = raw_reg;
        pend_next = pend_reg;
        up        = '0;
        down      = '0;
        rise      = item.line_levels & ~prev_reg & irr_pkg::active_lines();
        fall      = ~item.line_levels & prev_reg & irr_pkg::active_lines();
        rt          = '0;
        er          = '0;
        ef          = '0;
        lo          = '0;
        hi          = '0;
        pend_before = '0;
        pend_after  = '0;

        if (item.action == irr_pkg::ACT_WRITE)
        begin
            en_next = item.enable_value;
            for (int c = 0; c < irr_pkg::CPU_COUNT; c++)
            begin
                pend_next[c] = raw_reg[c] & item.enable_value;
            end
        end
        else
        begin
            prev_next = item.line_levels;
            graw_next = (graw_reg & ~fall) | rise;
            for (int c = 0; c < irr_pkg::CPU_COUNT; c++)
            begin
                for (int i = 0; i < irr_pkg::LINE_W; i++)
                begin
                    rt[i] = irr_pkg::routed(route_reg, i, c);
                end
                er = rise & en_reg & rt;
                ef = fall & en_reg & rt;
                raw_next[c]  = (raw_reg[c] & ~(fall & rt)) | (rise & rt);
                pend_next[c] = (pend_reg[c] & ~ef) | er;
                // Lines are taken in index order: below line i the new
                // pending bits apply, from line i up the old ones.
                for (int i = 0; i < irr_pkg::LINE_W; i++)
                begin
                    lo = '0;
                    for (int j = 0; j < irr_pkg::LINE_W; j++)
                    begin
                        if (j < i)
                        begin
                            lo[j] = 1'b1;
                        end
                    end
                    hi = lo;
                    hi[i] = 1'b1;
                    pend_before = (pend_next[c] & lo) | (pend_reg[c] & ~lo);
                    pend_after  = (pend_next[c] & hi) | (pend_reg[c] & ~hi);
                    if (er[i] && pend_before == '0)
                    begin
                        up[c] = 1'b1;
                    end
                    if (ef[i] && pend_after == '0)
                    begin
                        down[c] = 1'b1;
                    end
                end
            end
        end

        result.raise_mask    = up;
        result.drop_mask     = down & ~up;
        result.masked_status = graw_next & en_next;
        result.enable_now    = en_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_reg <= irr_pkg::ROUTE_RESET;
        end
        else if (cfg_we)
        begin
            route_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            graw_reg <= '0;
            en_reg   <= '0;
            raw_reg  <= '0;
            pend_reg <= '0;
        end
        else if (fire)
        begin
            prev_reg <= prev_next;
            graw_reg <= graw_next;
            en_reg   <= en_next;
            raw_reg  <= raw_next;
            pend_reg <= pend_next;
        end
    end

endmodule

`default_nettype wire

### design/irr_out_reg.sv
// Result register of the interrupt line router: holds a result until taken.
// Depends on irr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irr_out_reg (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  load,
    input  wire                  ready,
    input  irr_pkg::irr_result_t res_in,
    output logic                 valid,
    output logic                 free,
    output irr_pkg::irr_result_t res_out
);

    logic                 valid_reg;
    logic                 valid_next;
    irr_pkg::irr_result_t res_reg;

    assign free = !valid_reg || ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign valid   = valid_reg;
    assign res_out = res_reg;

endmodule

`default_nettype wire

### design/interrupt_line_router.sv
// Interrupt line router top level: input register, routing engine, result register.
// Depends on irr_pkg, irr_in_reg, irr_engine, irr_out_reg.
// Path: input register holds a transaction, then result register holds its result.
// One transaction per cycle unless m_tready stalls; the engine's state update is a single pass.
// Reset: rst_n asynchronous active low; clears all state, route map to 0x11111111.
`timescale 1ns / 1ps
`default_nettype none

module interrupt_line_router (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_we,
    input  wire  [irr_pkg::ROUTE_W-1:0]    cfg_wdata,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire  [irr_pkg::IN_DATA_W-1:0]  s_tdata,   // line_levels[7:0], enable_value[15:8]
    input  wire                            s_tuser,   // action
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [irr_pkg::OUT_DATA_W-1:0] m_tdata    // raise_mask[3:0], drop_mask[7:4],
                                                      // masked_status[15:8], enable_now[23:16]
);

    irr_pkg::irr_item_t   item_in;
    irr_pkg::irr_item_t   item_q;
    irr_pkg::irr_result_t result;
    irr_pkg::irr_result_t res_q;
    logic                 item_valid;
    logic                 out_free;
    logic                 fire;
    logic                 accept;

    assign item_in.action       = s_tuser;
    assign item_in.line_levels  = s_tdata[7:0];
    assign item_in.enable_value = s_tdata[15:8];

    assign fire     = item_valid && out_free;
    assign s_tready = !item_valid || out_free;
    assign accept   = s_tvalid && s_tready;

    irr_in_reg u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .drain    (fire),
        .item_in  (item_in),
        .valid    (item_valid),
        .item_out (item_q)
    );

    irr_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (item_q),
        .result    (result)
    );

    irr_out_reg u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (fire),
        .ready   (m_tready),
        .res_in  (result),
        .valid   (m_tvalid),
        .free    (out_free),
        .res_out (res_q)
    );

    assign m_tdata = res_q;

endmodule

`default_nettype wire

### design/irr_checker.sv
// Port-level checks of the interrupt line router, bound to the top level.
// Depends on irr_pkg and interrupt_line_router.
`timescale 1ns / 1ps
`default_nettype none

module irr_checker (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            s_tvalid,
    input wire                            s_tready,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [irr_pkg::OUT_DATA_W-1:0]  m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_raise_drop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:0] & m_tdata[7:4]) == 4'h0)
        else $error("raise and drop flagged for one cpu");

    a_status_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:8] & ~m_tdata[23:16]) == 8'h00)
        else $error("status shows a disabled line");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("no result after transaction");

endmodule

bind interrupt_line_router irr_checker u_irr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### test/interrupt_line_router_tb.sv
// Testbench for interrupt_line_router: a directed opening, then random line samples and
// enable writes under several route maps, checked against an in-bench routing model.
// Depends on irr_pkg and the interrupt_line_router RTL.
`timescale 1ns / 1ps

module interrupt_line_router_tb;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [irr_pkg::ROUTE_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [irr_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic s_tuser = irr_pkg::ACT_SAMPLE;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [irr_pkg::OUT_DATA_W-1:0] m_tdata;

    interrupt_line_router uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Routing model state
    logic [irr_pkg::ROUTE_W-1:0] route_copy = irr_pkg::ROUTE_RESET;
    irr_pkg::line_vec_t prev_lv = '0;
    irr_pkg::line_vec_t raw_all = '0;
    irr_pkg::line_vec_t en_mask = '0;
    irr_pkg::line_vec_t raw_cpu [irr_pkg::CPU_COUNT];
    irr_pkg::line_vec_t pend_cpu [irr_pkg::CPU_COUNT];

    irr_pkg::irr_item_t pending_items [$];
    irr_pkg::irr_result_t expected_results [$];
    irr_pkg::irr_item_t next_item;
    irr_pkg::irr_result_t want;
    irr_pkg::irr_result_t got;
    irr_pkg::line_vec_t gen_levels = '0;
    logic quiet = 1'b0;
    int failures = 0;

    initial
    begin
        for (int c = 0; c < irr_pkg::CPU_COUNT; c++)
        begin
            raw_cpu[c] = '0;
            pend_cpu[c] = '0;
        end
    end

    function automatic irr_pkg::irr_result_t route_step(irr_pkg::irr_item_t it);
        irr_pkg::irr_result_t r;
        irr_pkg::cpu_vec_t up;
        irr_pkg::cpu_vec_t down;
        up = '0;
        down = '0;
        if (it.action == irr_pkg::ACT_WRITE)
        begin
            for (int c = 0; c < irr_pkg::CPU_COUNT; c++)
            begin
                pend_cpu[c] = raw_cpu[c] & it.enable_value;
            end
            en_mask = it.enable_value;
        end
        else
        begin
            for (int i = 0; i < irr_pkg::NUM_LINES; i++)
            begin
                if (it.line_levels[i] && !prev_lv[i])
                begin
                    raw_all[i] = 1'b1;
                    for (int c = 0; c < irr_pkg::CPU_COUNT; c++)
                    begin
                        if (route_copy[i * irr_pkg::CPU_SLOT + c])
                        begin
                            raw_cpu[c][i] = 1'b1;
                            if (en_mask[i])
                            begin
                                if (pend_cpu[c] == '0)
                                begin
                                    up[c] = 1'b1;
                                end
                                pend_cpu[c][i] = 1'b1;
                            end
                        end
                    end
                end
                else if (!it.line_levels[i] && prev_lv[i])
                begin
                    raw_all[i] = 1'b0;
                    for (int c = 0; c < irr_pkg::CPU_COUNT; c++)
                    begin
                        if (route_copy[i * irr_pkg::CPU_SLOT + c])
                        begin
                            raw_cpu[c][i] = 1'b0;
                            if (en_mask[i])
                            begin
                                pend_cpu[c][i] = 1'b0;
                                if (pend_cpu[c] == '0)
                                begin
                                    down[c] = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            prev_lv = it.line_levels;
        end
        r.raise_mask = up;
        r.drop_mask = down & ~up;
        r.masked_status = raw_all & en_mask;
        r.enable_now = en_mask;
        return r;
    endfunction

    task automatic compare_field(string field, irr_pkg::line_vec_t want_v,
                                 irr_pkg::line_vec_t got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
            failures++;
        end
    endtask

    task automatic add_sample(irr_pkg::line_vec_t levels, irr_pkg::line_vec_t junk);
        irr_pkg::irr_item_t it;
        it.action = irr_pkg::ACT_SAMPLE;
        it.line_levels = levels;
        it.enable_value = junk;
        pending_items = {pending_items, it};
        gen_levels = levels;
    endtask

    task automatic add_write(irr_pkg::line_vec_t enable_v, irr_pkg::line_vec_t junk);
        irr_pkg::irr_item_t it;
        it.action = irr_pkg::ACT_WRITE;
        it.line_levels = junk;
        it.enable_value = enable_v;
        pending_items = {pending_items, it};
    endtask

    task automatic add_random(int count);
        int pick;
        irr_pkg::line_vec_t lv;
        irr_pkg::line_vec_t ev;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
            begin
                case ($urandom_range(7))
                    0: ev = '0;
                    1: ev = '1;
                    default: ev = irr_pkg::line_vec_t'($urandom);
                endcase
                add_write(ev, irr_pkg::line_vec_t'($urandom));
            end
            else
            begin
                lv = gen_levels;
                if (pick < 60)
                begin
                    lv[$urandom_range(irr_pkg::LINE_W - 1)] ^= 1'b1;
                    if ($urandom_range(1))
                    begin
                        lv[$urandom_range(irr_pkg::LINE_W - 1)] ^= 1'b1;
                    end
                end
                else if (pick < 85)
                begin
                    lv = irr_pkg::line_vec_t'($urandom);
                end
                else if (pick < 90)
                begin
                    lv = '0;
                end
                else if (pick < 95)
                begin
                    lv = '1;
                end
                add_sample(lv, irr_pkg::line_vec_t'($urandom));
            end
        end
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_route(logic [irr_pkg::ROUTE_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        route_copy = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results = {expected_results, route_step({s_tdata, s_tuser})};
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 21))
                begin
                    next_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {next_item.enable_value, next_item.line_levels};
                    s_tuser <= next_item.action;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected transaction, expected none, actual %0h",
                             $time, m_tdata);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("raise_mask", irr_pkg::line_vec_t'(want.raise_mask),
                                  irr_pkg::line_vec_t'(got.raise_mask));
                    compare_field("drop_mask", irr_pkg::line_vec_t'(want.drop_mask),
                                  irr_pkg::line_vec_t'(got.drop_mask));
                    compare_field("masked_status", want.masked_status, got.masked_status);
                    compare_field("enable_now", want.enable_now, got.enable_now);
                end
            end
            m_tready <= quiet || $urandom_range(99) >= 21;
        end
    end

    initial
    begin
        logic [irr_pkg::ROUTE_W-1:0] routes [6];
        routes[0] = 32'hFFFF_FFFF;
        routes[1] = 32'h0000_0000;
        routes[2] = 32'h8421_8421;
        routes[3] = $urandom;
        routes[4] = $urandom;
        routes[5] = $urandom;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset route: every line to CPU 0
        add_sample(8'h00, 8'hFF);
        add_write(8'hFF, 8'hAA);
        add_sample(8'hFF, 8'h00);
        add_sample(8'h00, 8'h55);
        add_sample(8'h01, 8'h00);
        add_sample(8'h02, 8'h00);   // drop and raise together: raise wins
        add_sample(8'h01, 8'h00);
        add_write(8'h00, 8'hFF);
        add_sample(8'h00, 8'hFF);   // fall on a disabled line
        add_sample(8'h80, 8'h00);   // rise on a disabled line
        add_write(8'hFF, 8'h00);
        add_sample(8'h00, 8'h00);
        add_sample(8'h55, 8'hAA);
        add_write(8'h0F, 8'h55);
        add_sample(8'hAA, 8'h0F);
        add_sample(8'hFF, 8'hF0);
        add_write(8'hF0, 8'hFF);
        add_sample(8'h00, 8'h00);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            write_route(routes[p]);
            quiet = (p == 2);
            add_sample(8'hFF, irr_pkg::line_vec_t'($urandom));
            add_sample(8'h00, irr_pkg::line_vec_t'($urandom));
            add_random(150);
            drain();
        end
        quiet = 1'b0;

        write_route(irr_pkg::ROUTE_RESET);
        add_random(40);
        drain();

        repeat (10) @(posedge clk);
        if (failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
